// ===== hdl/tkd_pkg.sv =====
// Package for the touch key dimmer controller: field widths, limits,
// register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package tkd_pkg;

    localparam int HOLD_W   = 10;
    localparam int LEVEL_W  = 7;
    localparam int KEYS     = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 10;

    typedef logic [HOLD_W-1:0]  t_hold;
    typedef logic [LEVEL_W-1:0] t_level;
    typedef logic [KEYS-1:0]    t_keys;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_hold  HOLD_MAX   = 10'd1023;
    localparam t_hold  STEP_HOLD  = 10'd2;
    localparam t_level LEVEL_MAX  = 7'd100;
    localparam t_hold  LONG_HOLD_RST = 10'd750;
    localparam t_level TOGGLE_RST    = 7'd50;

    // configuration register indexes
    localparam t_cfg_idx REG_LONG_HOLD = 1'd0;
    localparam t_cfg_idx REG_TOGGLE    = 1'd1;

    // func codes
    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_COMMAND = 1'b1;

endpackage

// ===== hdl/tkd_if.sv =====
// Channel interfaces for the touch key dimmer controller: input items,
// result items and configuration writes. Depends on tkd_pkg.
`timescale 1ns / 1ps

interface tkd_in_if;
    import tkd_pkg::*;
    logic   valid;
    logic   ready;
    logic   func;
    t_keys  key_levels;
    t_level set_level;
    modport source (output valid, output func, output key_levels, output set_level,
                    input ready);
    modport sink   (input valid, input func, input key_levels, input set_level,
                    output ready);
endinterface

interface tkd_out_if;
    import tkd_pkg::*;
    logic   valid;
    logic   ready;
    t_level target_level;
    t_level current_level;
    logic   publish_pulse;
    logic   reset_request;
    t_keys  pressed_mask;
    modport source (output valid, output target_level, output current_level,
                    output publish_pulse, output reset_request, output pressed_mask,
                    input ready);
    modport sink   (input valid, input target_level, input current_level,
                    input publish_pulse, input reset_request, input pressed_mask,
                    output ready);
endinterface

interface tkd_cfg_if;
    import tkd_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/touch_key_dimmer_controller_top.sv =====
// Channel     | dir | handshake   | payload
// i_in        | in  | valid/ready | func, key_levels, set_level
// o_out       | out | valid/ready | target/current level, publish, reset req, mask
// i_cfg       | in  | valid/ready | index, data (ready whenever out of reset)
//
// Two register stages: input register, then result register. An accepted item
// goes on to the result register; one item per cycle while o_out.ready is high.
// State (hold counters, phases, target, level) updates as an item moves from
// the input register to the result register. A stalled result register holds
// the input register, which then drops i_in.ready.
// i_rst_n is synchronous; it clears state, control and config to defaults.
// Both ready outputs stay low while i_rst_n is low.
// Depends on tkd_pkg and tkd_if.
`timescale 1ns / 1ps

module touch_key_dimmer_controller_top (
    input  logic i_clk,
    input  logic i_rst_n,
    tkd_in_if.sink    i_in,
    tkd_out_if.source o_out,
    tkd_cfg_if.sink   i_cfg
);
    import tkd_pkg::*;

    // config
    t_hold  r_long_hold;
    t_level r_toggle;

    // input register
    logic   r_in_valid;
    logic   r_in_func;
    t_keys  r_in_keys;
    t_level r_in_set;

    // result register
    logic   r_out_valid;
    t_level r_out_target;
    t_level r_out_level;
    logic   r_out_publish;
    logic   r_out_rst_req;
    t_keys  r_out_pressed;

    // block state
    t_hold  r_hold [KEYS];
    logic   r_up;
    logic   r_down;
    t_level r_target;
    t_level r_level;
    logic   r_pend;

    t_hold  n_hold [KEYS];
    logic   n_up;
    logic   n_down;
    t_level n_target;
    t_level n_level;
    logic   n_pend;

    logic   w_adv;
    logic   w_fire;
    logic   w_publish;
    logic   w_rst_req;
    t_keys  w_pressed;
    t_level w_toggle_sat;

    assign w_adv  = !r_out_valid || o_out.ready;
    assign w_fire = r_in_valid && w_adv;

    assign i_in.ready  = i_rst_n && (!r_in_valid || w_adv);
    assign i_cfg.ready = i_rst_n;

    assign o_out.valid         = r_out_valid;
    assign o_out.target_level  = r_out_target;
    assign o_out.current_level = r_out_level;
    assign o_out.publish_pulse = r_out_publish;
    assign o_out.reset_request = r_out_rst_req;
    assign o_out.pressed_mask  = r_out_pressed;

    assign w_toggle_sat = (r_toggle > LEVEL_MAX) ? LEVEL_MAX : r_toggle;

    always_comb begin
        for (int i = 0; i < KEYS; i++) begin
            n_hold[i] = r_hold[i];
        end
        n_up      = r_up;
        n_down    = r_down;
        n_target  = r_target;
        n_level   = r_level;
        n_pend    = r_pend;
        w_publish = 1'b0;
        w_rst_req = 1'b0;
        w_pressed = '0;
        if (r_in_func == FUNC_COMMAND) begin
            if (r_in_set <= LEVEL_MAX) begin
                n_target = r_in_set;
            end
            w_publish = 1'b1;
        end else begin
            w_pressed = ~r_in_keys;
            for (int i = 0; i < KEYS; i++) begin
                if (w_pressed[i]) begin
                    if (r_hold[i] != HOLD_MAX) begin
                        n_hold[i] = r_hold[i] + 1'b1;
                    end
                end else begin
                    if (r_hold[i] >= r_long_hold) begin
                        w_rst_req = 1'b1;
                    end
                    n_hold[i] = '0;
                end
            end
            // key 0: step up on every second held tick, only while the target is nonzero
            if (n_hold[0] >= STEP_HOLD) begin
                n_up = !r_up;
                if (n_up && n_target != '0 && n_target < LEVEL_MAX) begin
                    n_target = n_target + 1'b1;
                    n_pend   = 1'b1;
                end
            end
            // key 1: on/off toggle on second held tick only
            if (n_hold[1] == STEP_HOLD) begin
                n_target = (n_target == '0) ? w_toggle_sat : '0;
                n_pend   = 1'b1;
            end
            // key 2: step down, floor at 1
            if (n_hold[2] >= STEP_HOLD) begin
                n_down = !r_down;
                if (n_down && n_target > 7'd1) begin
                    n_target = n_target - 1'b1;
                    n_pend   = 1'b1;
                end
            end
            if (n_pend && w_pressed == '0) begin
                n_pend    = 1'b0;
                w_publish = 1'b1;
            end
            if (r_level < n_target) begin
                n_level = r_level + 1'b1;
            end else if (r_level > n_target) begin
                n_level = r_level - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_long_hold <= LONG_HOLD_RST;
            r_toggle    <= TOGGLE_RST;
            for (int i = 0; i < KEYS; i++) begin
                r_hold[i] <= '0;
            end
            r_up     <= 1'b0;
            r_down   <= 1'b0;
            r_target <= '0;
            r_level  <= '0;
            r_pend   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_LONG_HOLD: r_long_hold <= i_cfg.data[HOLD_W-1:0];
                    REG_TOGGLE:    r_toggle    <= i_cfg.data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                for (int i = 0; i < KEYS; i++) begin
                    r_hold[i] <= n_hold[i];
                end
                r_up     <= n_up;
                r_down   <= n_down;
                r_target <= n_target;
                r_level  <= n_level;
                r_pend   <= n_pend;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_func <= i_in.func;
            r_in_keys <= i_in.key_levels;
            r_in_set  <= i_in.set_level;
        end
        if (w_fire) begin
            r_out_target  <= n_target;
            r_out_level   <= n_level;
            r_out_publish <= w_publish;
            r_out_rst_req <= w_rst_req;
            r_out_pressed <= w_pressed;
        end
    end

`ifndef SYNTHESIS
    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.target_level <= LEVEL_MAX)
        else $error("target level above maximum");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.current_level <= LEVEL_MAX)
        else $error("current level above maximum");

    a_level_ramp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_level == $past(r_level) || r_level == $past(r_level) + 7'd1
                    || r_level == $past(r_level) - 7'd1))
        else $error("level moved more than one step");

    a_publish_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.publish_pulse) |-> o_out.pressed_mask == '0)
        else $error("publish while a key is pressed");
`endif

endmodule
